// ----- hw/rtl/lsm_pkg.sv -----
// ----------------------------------------------------------------------------
// lsm_pkg: shared types and constants of the line substring matcher
// Request codes, register indexes, result kinds and fixed field widths.
// ----------------------------------------------------------------------------
package lsm_pkg;

  // default and upper bound of the search string length
  localparam int unsigned PATTERN_MAX_DEF = 16;
  // bytes held by the two pattern registers together
  localparam int unsigned PAT_BYTES       = 16;
  localparam int unsigned PAT_IDX_W       = 4;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned LEN_REG_W       = 5;

  localparam logic [BYTE_W-1:0] NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] NUL       = 8'h00;

  // input request codes
  typedef enum logic [OP_W-1:0] {
    OP_DATA = 2'd0,
    OP_EOF  = 2'd1,
    OP_EOS  = 2'd2
  } op_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  // result kinds
  localparam logic KIND_LINE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

// ----- hw/rtl/lsm_intf.sv -----
// ----------------------------------------------------------------------------
// lsm_intf: channel interfaces of the line substring matcher
// Text input, result output and configuration write channels.
// ----------------------------------------------------------------------------

// text input channel
interface lsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] text_byte;

  modport source (output valid, output op, output text_byte, input ready);
  modport sink   (input valid, input op, input text_byte, output ready);
  modport mon    (input valid, input op, input text_byte, input ready);
endinterface

// result output channel
interface lsm_out_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic matched;

  modport source (output valid, output result_kind, output matched, input ready);
  modport sink   (input valid, input result_kind, input matched, output ready);
  modport mon    (input valid, input result_kind, input matched, input ready);
endinterface

// configuration write channel
interface lsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
  modport mon    (input valid, input index, input data, input ready);
endinterface

// ----- hw/rtl/lsm_cfg.sv -----
// ----------------------------------------------------------------------------
// lsm_cfg: pattern registers of the line substring matcher
// Holds the search string and its length, derives the effective length and
// the byte each window cell compares against.
// ----------------------------------------------------------------------------
module lsm_cfg #(
  parameter int unsigned PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF,
  localparam int unsigned LenW       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  lsm_cfg_if.sink                            cfg_i,
  output logic [LenW-1:0]                    eff_len_o,
  output logic [PATTERN_MAX-1:0][lsm_pkg::BYTE_W-1:0] expect_o,
  output logic [PATTERN_MAX-1:0]             care_o
);
  import lsm_pkg::*;

  logic [CFG_DATA_W-1:0]          pat_lo_q, pat_lo_d;
  logic [CFG_DATA_W-1:0]          pat_hi_q, pat_hi_d;
  logic [LEN_REG_W-1:0]           len_q, len_d;
  logic [PAT_BYTES-1:0][BYTE_W-1:0] pat;
  logic [LenW-1:0]                len_clip;
  logic [LenW-1:0]                eff_len;

  assign cfg_i.ready = 1'b1;

  // register writes
  always_comb begin
    pat_lo_d = pat_lo_q;
    pat_hi_d = pat_hi_q;
    len_d    = len_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PAT_LOW:  pat_lo_d = cfg_i.data;
        CFG_PAT_HIGH: pat_hi_d = cfg_i.data;
        CFG_PAT_LEN:  len_d    = cfg_i.data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= '0;
    end else begin
      pat_lo_q <= pat_lo_d;
      pat_hi_q <= pat_hi_d;
      len_q    <= len_d;
    end
  end

  assign pat = {pat_hi_q, pat_lo_q};

  // clip length, then stop at the first zero byte of the string
  always_comb begin
    if (len_q > LEN_REG_W'(PATTERN_MAX)) begin
      len_clip = LenW'(PATTERN_MAX);
    end else begin
      len_clip = LenW'(len_q);
    end
    eff_len = len_clip;
    for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
      if (LenW'(i) < len_clip && pat[i] == NUL) begin
        eff_len = LenW'(i);
      end
    end
  end

  assign eff_len_o = eff_len;

  // cell i compares the byte i places back, so it checks pattern byte len-1-i
  always_comb begin
    logic [LenW-1:0] pos;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pos         = eff_len - LenW'(1) - LenW'(i);
      care_o[i]   = LenW'(i) < eff_len;
      expect_o[i] = pat[PAT_IDX_W'(pos)];
    end
  end

endmodule

// ----- hw/rtl/lsm_cell.sv -----
// ----------------------------------------------------------------------------
// lsm_cell: one window cell of the line substring matcher
// Holds one recent text byte, passes it on to the next cell on each text
// byte and compares the byte it takes in with its expected pattern byte.
// ----------------------------------------------------------------------------
module lsm_cell (
  input  logic                        clk_i,
  input  logic                        shift_i,
  input  logic [lsm_pkg::BYTE_W-1:0]  byte_i,
  input  logic [lsm_pkg::BYTE_W-1:0]  expect_i,
  input  logic                        care_i,
  output logic [lsm_pkg::BYTE_W-1:0]  byte_o,
  output logic                        eq_o
);
  import lsm_pkg::*;

  logic [BYTE_W-1:0] byte_q;

  // byte shift, payload only
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // compare the byte entering this cell, positions past the length always pass
  assign eq_o   = !care_i || (byte_i == expect_i);
  assign byte_o = byte_q;

endmodule

// ----- hw/rtl/line_substring_matcher.sv -----
// ----------------------------------------------------------------------------
// line_substring_matcher: fixed-string search over lines of a byte stream
// Reports per line whether it holds the configured string, plus summaries.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   text requests: op data byte, end of file or end of search.
//   out_o  results: a line verdict (result_kind 0) or a search summary
//          (result_kind 1), each with its matched bit.
//   cfg_i  pattern writes: index 0 low bytes, 1 high bytes, 2 length; always
//          ready, write only while no request is in flight.
// Throughput is one request per cycle while the receiver does not stall. A
// result is shown in the cycle after the request that causes it, from a single
// output register. A window of PATTERN_MAX cells shifts the text bytes and
// compares all positions in parallel, so a line verdict is ready as its newline
// is taken. When the receiver stalls, the output register holds its result and
// in_i stays ready only while that register is empty or being emptied, so a
// stall on out_o reaches in_i in the same cycle.
// Reset clears the pattern registers, the line state and the summary flag;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module line_substring_matcher #(
  parameter int unsigned PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsm_in_if.sink    in_i,
  lsm_out_if.source out_o,
  lsm_cfg_if.sink   cfg_i
);
  import lsm_pkg::*;

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  logic [LenW-1:0]                  eff_len;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] expect_b;
  logic [PATTERN_MAX-1:0]           care;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] cell_byte;
  logic [PATTERN_MAX-1:0]           cell_eq;

  logic                             accept;
  logic                             shift;
  logic [LenW-1:0]                  bic_q, bic_d, bic_inc;
  logic                             line_hit_q, line_hit_d;
  logic                             after_nul_q, after_nul_d;
  logic                             any_hit_q, any_hit_d;
  logic                             nul_now, win_hit, line_now;
  logic                             emit, emit_kind, emit_match;
  logic                             out_valid_q, out_valid_d;
  logic                             out_kind_q, out_match_q;

  // pattern registers
  lsm_cfg #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .eff_len_o (eff_len),
    .expect_o  (expect_b),
    .care_o    (care)
  );

  assign accept = in_i.valid && in_i.ready;
  assign shift  = accept && (in_i.op == OP_DATA);

  // window cells, cell 0 takes the incoming byte
  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    logic [BYTE_W-1:0] feed;
    if (g == 0) begin : g_head
      assign feed = in_i.text_byte;
    end else begin : g_link
      assign feed = cell_byte[g-1];
    end
    lsm_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .byte_i   (feed),
      .expect_i (expect_b[g]),
      .care_i   (care[g]),
      .byte_o   (cell_byte[g]),
      .eq_o     (cell_eq[g])
    );
  end

  // match of the window that includes the incoming byte
  assign bic_inc  = (bic_q == LenW'(PATTERN_MAX)) ? bic_q : bic_q + LenW'(1);
  assign nul_now  = after_nul_q || (in_i.text_byte == NUL);
  assign win_hit  = !nul_now && (eff_len != '0) && (bic_inc >= eff_len) && (&cell_eq);
  assign line_now = line_hit_q || win_hit;

  // line state and result selection
  always_comb begin
    bic_d       = bic_q;
    line_hit_d  = line_hit_q;
    after_nul_d = after_nul_q;
    any_hit_d   = any_hit_q;
    emit        = 1'b0;
    emit_kind   = KIND_LINE;
    emit_match  = 1'b0;
    if (accept) begin
      case (in_i.op)
        OP_DATA: begin
          if (in_i.text_byte == NEWLINE) begin
            emit        = 1'b1;
            emit_match  = line_now || (eff_len == '0);
            any_hit_d   = any_hit_q || emit_match;
            bic_d       = '0;
            line_hit_d  = 1'b0;
            after_nul_d = 1'b0;
          end else begin
            bic_d       = bic_inc;
            line_hit_d  = line_now;
            after_nul_d = nul_now;
          end
        end
        OP_EOF: begin
          if (bic_q != '0) begin
            emit        = 1'b1;
            emit_match  = line_hit_q || (eff_len == '0);
            any_hit_d   = any_hit_q || emit_match;
            bic_d       = '0;
            line_hit_d  = 1'b0;
            after_nul_d = 1'b0;
          end
        end
        OP_EOS: begin
          emit        = 1'b1;
          emit_kind   = KIND_SUMMARY;
          emit_match  = any_hit_q;
          any_hit_d   = 1'b0;
          bic_d       = '0;
          line_hit_d  = 1'b0;
          after_nul_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bic_q       <= '0;
      line_hit_q  <= 1'b0;
      after_nul_q <= 1'b0;
      any_hit_q   <= 1'b0;
    end else begin
      bic_q       <= bic_d;
      line_hit_q  <= line_hit_d;
      after_nul_q <= after_nul_d;
      any_hit_q   <= any_hit_d;
    end
  end

  // output register
  assign in_i.ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_kind_q  <= emit_kind;
      out_match_q <= emit_match;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.matched     = out_match_q;

endmodule

// ----- hw/rtl/lsm_checker.sv -----
// ----------------------------------------------------------------------------
// lsm_checker: port checks of the line substring matcher
// Result timing, summary clearing and output hold under stall.
// ----------------------------------------------------------------------------
module lsm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  lsm_in_if.sink    in_m,
  lsm_out_if.source out_m
);
  import lsm_pkg::*;

  logic in_acc;
  logic eos_acc;
  logic nl_acc;

  assign in_acc  = in_m.valid && in_m.ready;
  assign eos_acc = in_acc && (in_m.op == OP_EOS);
  assign nl_acc  = in_acc && (in_m.op == OP_DATA) && (in_m.text_byte == NEWLINE);

  // end of search gives a summary in the next cycle
  a_eos_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eos_acc |=> out_m.valid && (out_m.result_kind == KIND_SUMMARY))
    else $error("end of search without summary");

  // newline gives a line verdict in the next cycle
  a_nl_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nl_acc |=> out_m.valid && (out_m.result_kind == KIND_LINE))
    else $error("newline without line verdict");

  // back-to-back summaries: the second one sees a cleared flag
  a_eos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eos_acc ##1 eos_acc |=> out_m.valid && !out_m.matched)
    else $error("summary flag not cleared");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid && !out_m.ready |=>
      out_m.valid && $stable(out_m.result_kind) && $stable(out_m.matched))
    else $error("stalled result changed");

endmodule

bind line_substring_matcher lsm_checker u_lsm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_m   (in_i),
  .out_m  (out_o)
);

// ----- bench/line_match_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_match_checker: result checker for the line substring matcher
// Watches the text, result and pattern channels, keeps its own copy of the
// pattern registers and the line state, predicts each line verdict and search
// summary, and compares every result taken from the block in order.
// ----------------------------------------------------------------------------
module line_match_checker
  import lsm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  lsm_in_if.mon  in_m,
  lsm_out_if.mon out_m,
  lsm_cfg_if.mon cfg_m,
  output int     mismatches_o,
  output int     awaited_o
);

  localparam int unsigned WIN = PAT_BYTES;

  typedef struct packed {
    logic kind;
    logic matched;
  } verdict_t;

  // verdicts and summaries still owed by the block, oldest first
  verdict_t expected_verdicts[$];

  // pattern registers as last written
  logic [CFG_DATA_W-1:0] pat_low_q;
  logic [CFG_DATA_W-1:0] pat_high_q;
  logic [LEN_REG_W-1:0]  pat_len_q;

  // line state
  logic [BYTE_W-1:0]     recent_q [WIN];
  logic [LEN_REG_W-1:0]  line_bytes_q;
  logic                  line_hit_q;
  logic                  saw_nul_q;
  logic                  any_hit_q;
  int                    mismatches;

  function automatic logic [BYTE_W-1:0] search_byte(int unsigned i);
    logic [2*CFG_DATA_W-1:0] all_bytes;
    all_bytes = {pat_high_q, pat_low_q};
    return all_bytes[8*i +: 8];
  endfunction

  // string length in use: clipped to the maximum, cut at the first zero byte
  function automatic int unsigned search_length();
    int unsigned n;
    int unsigned i;
    n = (pat_len_q > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : pat_len_q;
    for (i = 0; i < n; i++) begin
      if (search_byte(i) == NUL) return i;
    end
    return n;
  endfunction

  task automatic clear_line();
    line_bytes_q = '0;
    line_hit_q   = 1'b0;
    saw_nul_q    = 1'b0;
  endtask

  task automatic close_line();
    verdict_t v;
    v.kind    = KIND_LINE;
    v.matched = line_hit_q || (search_length() == 0);
    if (v.matched) any_hit_q = 1'b1;
    expected_verdicts.push_back(v);
    clear_line();
  endtask

  // advance the line state by one request and queue what it owes
  task automatic predict_line_search(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
    int unsigned len;
    int unsigned i;
    logic        same;
    verdict_t    v;
    case (op)
      OP_DATA: begin
        len = search_length();
        for (i = WIN - 1; i > 0; i--) recent_q[i] = recent_q[i-1];
        recent_q[0] = b;
        if (line_bytes_q < WIN) line_bytes_q++;
        if (b == NUL) saw_nul_q = 1'b1;
        if (!saw_nul_q && len > 0 && line_bytes_q >= len) begin
          same = 1'b1;
          for (i = 0; i < len; i++) begin
            if (search_byte(i) != recent_q[len-1-i]) same = 1'b0;
          end
          if (same) line_hit_q = 1'b1;
        end
        if (b == NEWLINE) close_line();
      end
      OP_EOF: begin
        if (line_bytes_q > 0) close_line();
      end
      OP_EOS: begin
        clear_line();
        v.kind    = KIND_SUMMARY;
        v.matched = any_hit_q;
        any_hit_q = 1'b0;
        expected_verdicts.push_back(v);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t oldest;
    int       i;
    if (!rst_ni) begin
      expected_verdicts.delete();
      pat_low_q  = '0;
      pat_high_q = '0;
      pat_len_q  = '0;
      for (i = 0; i < WIN; i++) recent_q[i] = '0;
      clear_line();
      any_hit_q  = 1'b0;
      mismatches = 0;
      mismatches_o <= 0;
      awaited_o    <= 0;
    end else begin
      // results leaving the block
      if (out_m.valid && out_m.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with none awaited: result_kind %0b matched %0b",
                 out_m.result_kind, out_m.matched);
          mismatches++;
        end else begin
          oldest = expected_verdicts.pop_front();
          if (out_m.result_kind !== oldest.kind) begin
            $error("result_kind: expected %0b, actual %0b", oldest.kind, out_m.result_kind);
            mismatches++;
          end
          if (out_m.matched !== oldest.matched) begin
            $error("matched: expected %0b, actual %0b", oldest.matched, out_m.matched);
            mismatches++;
          end
        end
      end
      // text requests use the pattern as it stood before this edge
      if (in_m.valid && in_m.ready) predict_line_search(in_m.op, in_m.text_byte);
      // pattern register writes
      if (cfg_m.valid && cfg_m.ready) begin
        case (cfg_m.index)
          CFG_PAT_LOW:  pat_low_q  = cfg_m.data;
          CFG_PAT_HIGH: pat_high_q = cfg_m.data;
          CFG_PAT_LEN:  pat_len_q  = cfg_m.data[LEN_REG_W-1:0];
          default: ;
        endcase
      end
      mismatches_o <= mismatches;
      awaited_o    <= expected_verdicts.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level bench of the line substring matcher
// Feeds directed and random text streams under a series of search strings,
// varies sender gaps and receiver stalls, and leaves all checking to the
// result checker and the port checks bound to the block.
// ----------------------------------------------------------------------------
module testbench;
  import lsm_pkg::*;

  localparam int unsigned ITEMS_TOTAL = 1350;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned LONG_STALL  = 64;
  localparam int unsigned SETTLE      = 4;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;

  lsm_in_if  in_if ();
  lsm_out_if out_if ();
  lsm_cfg_if cfg_if ();

  int mismatches;
  int awaited;

  // stimulus side copy of the search string, used to build text that hits
  logic [BYTE_W-1:0] pat_text [PAT_BYTES];
  int unsigned       pat_n;
  int unsigned       sent_count;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       stall_requests;
  int unsigned       stalls_served;

  line_substring_matcher DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  line_match_checker match_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_m         (in_if),
    .out_m        (out_if),
    .cfg_m        (cfg_if),
    .mismatches_o (mismatches),
    .awaited_o    (awaited)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  // result receiver: random stalls, plus long hold-offs on request
  initial begin : result_sink
    out_if.ready  = 1'b0;
    stalls_served = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stalls_served < stall_requests) begin
        out_if.ready <= 1'b0;
        stalls_served++;
        repeat (LONG_STALL) @(posedge clk_i);
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one text request, after a random gap
  task automatic send_req(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.text_byte <= data;
    do @(posedge clk_i); while (!in_if.ready);
    if (op != OP_UNUSED) sent_count++;
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_req(OP_DATA, s[k]);
  endtask

  // stop offering and wait until every result is back and the block is quiet
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic load_pattern(input logic [2*CFG_DATA_W-1:0] bytes, input logic [LEN_REG_W-1:0] len);
    int unsigned i;
    write_reg(CFG_PAT_LOW, bytes[CFG_DATA_W-1:0]);
    write_reg(CFG_PAT_HIGH, bytes[2*CFG_DATA_W-1:CFG_DATA_W]);
    write_reg(CFG_PAT_LEN, {{(CFG_DATA_W-LEN_REG_W){1'b0}}, len});
    cfg_if.valid <= 1'b0;
    pat_n = (len > PAT_BYTES) ? PAT_BYTES : len;
    for (i = 0; i < PAT_BYTES; i++) pat_text[i] = bytes[8*i +: 8];
  endtask

  function automatic logic [BYTE_W-1:0] alpha_byte();
    return $urandom_range(1) ? "a" : "b";
  endfunction

  // mostly bytes of the search string, some noise, rare nul and newline
  function automatic logic [BYTE_W-1:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55 && pat_n > 0) return pat_text[$urandom_range(pat_n - 1)];
    if (r < 80) return alpha_byte();
    if (r < 84) return NUL;
    if (r < 87) return NEWLINE;
    return $urandom_range(255);
  endfunction

  // search string for a random phase; the first three are the extremes
  task automatic choose_pattern(input int unsigned p, output logic [2*CFG_DATA_W-1:0] bytes,
                                output logic [LEN_REG_W-1:0] len);
    int unsigned i;
    int unsigned top;
    bytes = {$urandom, $urandom, $urandom, $urandom};
    if (p == 0) begin
      len = PAT_BYTES;
      for (i = 0; i < PAT_BYTES; i++) bytes[8*i +: 8] = alpha_byte();
    end else if (p == 1) begin
      bytes = '1;
      len   = '1;
    end else if (p == 2) begin
      bytes = '0;
      len   = '0;
    end else begin
      len = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 6);
      for (i = 0; i < PAT_BYTES; i++) begin
        if ($urandom_range(7) != 0) bytes[8*i +: 8] = alpha_byte();
      end
      top = (len > PAT_BYTES) ? PAT_BYTES : len;
      // newline as the last byte of the string
      if (top > 0 && $urandom_range(2) == 0) bytes[8*(top-1) +: 8] = NEWLINE;
      // zero byte inside the string cuts it short
      if (top > 1 && $urandom_range(4) == 0) bytes[8*$urandom_range(top-1) +: 8] = NUL;
    end
  endtask

  // one line of random text, hits planted often, with a random ending
  task automatic send_line();
    int unsigned n;
    int unsigned k;
    int unsigned j;
    int unsigned flip;
    int unsigned ending;
    n = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 12);
    k = 0;
    while (k < n) begin
      if (pat_n > 0 && $urandom_range(4) == 0) begin
        flip = ($urandom_range(2) == 0) ? $urandom_range(pat_n - 1) : PAT_BYTES;
        for (j = 0; j < pat_n; j++) send_req(OP_DATA, (j == flip) ? alpha_byte() : pat_text[j]);
        k += pat_n;
      end else begin
        send_req(OP_DATA, pick_text_byte());
        k++;
      end
    end
    ending = $urandom_range(99);
    if (ending < 80) begin
      send_req(OP_DATA, NEWLINE);
    end else if (ending < 90) begin
      send_req(OP_EOF, $urandom_range(255));
    end else if (ending < 96) begin
      send_req(OP_EOS, $urandom_range(255));
    end else begin
      send_req(OP_UNUSED, $urandom_range(255));
      send_req(OP_DATA, NEWLINE);
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    logic [2*CFG_DATA_W-1:0] pat_bits;
    logic [LEN_REG_W-1:0]    pat_len;
    int unsigned             p;
    int unsigned             phase_end;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.op        = OP_DATA;
    in_if.text_byte = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_PAT_LOW;
    cfg_if.data     = '0;
    pat_n           = 0;
    sent_count      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    stall_requests  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty string after reset matches every line
    send_text("q\n");
    send_req(OP_EOF, 8'hFF);   // nothing pending, no verdict
    send_req(OP_EOS, 8'h00);
    send_req(OP_EOS, 8'hFF);   // flag already cleared
    wait_idle();

    // plain two byte string
    load_pattern({64'h0, 64'h6261}, 5'd2);
    send_text("xab\n");
    // nul stops matching, line closed by end of file
    send_req(OP_DATA, "a");
    send_req(OP_DATA, NUL);
    send_text("ab");
    send_req(OP_EOF, 8'h00);
    // end of search drops the pending line
    send_req(OP_DATA, 8'hFF);
    send_req(OP_DATA, "a");
    send_req(OP_EOS, 8'h55);
    send_req(OP_UNUSED, 8'hA5);
    wait_idle();

    // string cut by a zero byte, ending in newline
    load_pattern({64'h0, 64'h7A00_0A62}, 5'd4);
    send_text("ab\n");
    send_text("b");
    send_req(OP_EOF, 8'h00);
    send_req(OP_EOS, 8'h00);

    // random phases, each under its own search string
    for (p = 0; p < PHASES; p++) begin
      choose_pattern(p, pat_bits, pat_len);
      wait_idle();
      load_pattern(pat_bits, pat_len);
      if (p < 3) begin
        send_idle_pct  = 11;
        recv_stall_pct = 77;
      end else if (p < 6) begin
        send_idle_pct  = 77;
        recv_stall_pct = 11;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      // long receiver hold-off while text keeps coming
      if (p == 1 || p == 4 || p == 7) stall_requests++;
      phase_end = sent_count + ITEMS_TOTAL / PHASES;
      while (sent_count < phase_end) begin
        if ($urandom_range(19) == 0) send_req($urandom_range(3), $urandom_range(255));
        else send_line();
      end
    end
    wait_idle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
